>>> src/interrupt_status_routing_and_readback_defines.svh
// ----------------------------------------------------------------------------
// Interrupt status routing and readback: assertion macros
// Shared assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_STATUS_ROUTING_AND_READBACK_DEFINES_SVH
`define INTERRUPT_STATUS_ROUTING_AND_READBACK_DEFINES_SVH

`ifndef SYNTHESIS
`define ISR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ISR_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISR_ASSERT(name, prop, msg)
`define ISR_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

>>> src/isr_pkg.sv
// ----------------------------------------------------------------------------
// Interrupt status routing and readback: package
// Sizes, operation codes, register offsets and the source bit table.
// ----------------------------------------------------------------------------
package isr_pkg;

	localparam int RF_DEPTH = 256;
	localparam int RF_AW    = 8;
	localparam int DW       = 8;
	localparam int CLR_W    = RF_AW + 1;

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_EVENT = 2'd2;

	localparam logic [RF_AW-1:0] OFS_IRQ_EN  = 8'h92;
	localparam logic [RF_AW-1:0] OFS_FIRQ_EN = 8'h93;
	localparam logic [RF_AW-1:0] OFS_CONST_A = 8'h94;
	localparam logic [RF_AW-1:0] OFS_CONST_B = 8'h95;
	localparam logic [DW-1:0]    CONST_READ  = 8'd126;

	localparam logic CFG_IRQ_ON  = 1'b0;
	localparam logic CFG_FIRQ_ON = 1'b1;

	localparam logic [1:0] SRC_KEYBOARD   = 2'd0;
	localparam logic [1:0] SRC_VERTICAL   = 2'd1;
	localparam logic [1:0] SRC_HORIZONTAL = 2'd2;
	localparam logic [1:0] SRC_TIMER      = 2'd3;

	function automatic logic [DW-1:0] source_bit(input logic [1:0] src);
		logic [DW-1:0] b;
		case (src)
			SRC_KEYBOARD:   b = 8'd2;
			SRC_VERTICAL:   b = 8'd8;
			SRC_HORIZONTAL: b = 8'd16;
			SRC_TIMER:      b = 8'd32;
			default:        b = '0;
		endcase
		return b;
	endfunction

endpackage

>>> src/isr_ram.sv
// ----------------------------------------------------------------------------
// Interrupt status routing and readback: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module isr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/interrupt_status_routing_and_readback.sv
// Latency: a result strobes on done in the cycle after its command is taken.
// Throughput: one command per cycle; the register file RAM read is the only stage.
// Reset: busy stays high for 256 cycles while the register file is swept to zero,
// one entry per cycle; configuration writes are taken throughout.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// Interrupt status routing and readback
// Register file in RAM, latched fast and normal pending masks, event routing.
// ----------------------------------------------------------------------------
`include "interrupt_status_routing_and_readback_defines.svh"

module interrupt_status_routing_and_readback import isr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       func,
	input  logic [RF_AW-1:0] port,
	input  logic [DW-1:0]    write_data,
	input  logic [1:0]       source,
	output logic             done,
	output logic [DW-1:0]    read_data,
	output logic             assert_irq,
	output logic             assert_firq,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic             cfg_data
);

	logic [CLR_W-1:0] clr_cnt_q;
	logic             clearing;
	logic             accept;

	logic             ram_we;
	logic [RF_AW-1:0] ram_waddr;
	logic [DW-1:0]    ram_wdata;
	logic [DW-1:0]    ram_rdata;

	logic [DW-1:0]    irq_en_q;
	logic [DW-1:0]    firq_en_q;
	logic [DW-1:0]    irq_mask_q;
	logic [DW-1:0]    firq_mask_q;
	logic             irq_on_q;
	logic             firq_on_q;

	logic [DW-1:0]    src_bit;
	logic             fire_firq;
	logic             fire_irq;
	logic [DW-1:0]    rd_imm;
	logic             use_ram;

	logic             done_s1;
	logic             irq_s1;
	logic             firq_s1;
	logic             use_ram_s1;
	logic [DW-1:0]    rd_imm_s1;

	assign clearing  = ~clr_cnt_q[CLR_W-1];
	assign busy      = clearing;
	assign accept    = start & ~busy;
	assign cfg_ready = 1'b1;

	assign ram_we    = clearing | (accept & (func == FUNC_WRITE));
	assign ram_waddr = clearing ? clr_cnt_q[RF_AW-1:0] : port;
	assign ram_wdata = clearing ? '0 : write_data;

	isr_ram #(
		.WIDTH(DW),
		.DEPTH(RF_DEPTH)
	) u_rf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(port),
		.rdata(ram_rdata)
	);

	always_comb begin
		src_bit   = source_bit(source);
		fire_firq = (func == FUNC_EVENT) & (|(firq_en_q & src_bit)) & firq_on_q;
		fire_irq  = (func == FUNC_EVENT) & ~fire_firq & (|(irq_en_q & src_bit)) & irq_on_q;
		rd_imm    = '0;
		use_ram   = 1'b0;
		if (func == FUNC_READ) begin
			case (port)
				OFS_IRQ_EN:  rd_imm = irq_mask_q;
				OFS_FIRQ_EN: rd_imm = firq_mask_q;
				OFS_CONST_A: rd_imm = CONST_READ;
				OFS_CONST_B: rd_imm = CONST_READ;
				default:     use_ram = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_on_q  <= 1'b0;
			firq_on_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IRQ_ON:  irq_on_q  <= cfg_data;
				CFG_FIRQ_ON: firq_on_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Enable byte copies (events need no RAM read) and the pending masks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_en_q    <= '0;
			firq_en_q   <= '0;
			irq_mask_q  <= '0;
			firq_mask_q <= '0;
		end else if (accept) begin
			case (func)
				FUNC_READ: begin
					if (port == OFS_IRQ_EN) begin
						irq_mask_q <= '0;
					end
					if (port == OFS_FIRQ_EN) begin
						firq_mask_q <= '0;
					end
				end
				FUNC_WRITE: begin
					if (port == OFS_IRQ_EN) begin
						irq_en_q <= write_data;
					end
					if (port == OFS_FIRQ_EN) begin
						firq_en_q <= write_data;
					end
				end
				FUNC_EVENT: begin
					if (fire_firq) begin
						firq_mask_q <= firq_mask_q | src_bit;
					end
					if (fire_irq) begin
						irq_mask_q <= irq_mask_q | src_bit;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1    <= 1'b0;
			irq_s1     <= 1'b0;
			firq_s1    <= 1'b0;
			use_ram_s1 <= 1'b0;
		end else begin
			done_s1    <= accept;
			irq_s1     <= accept & fire_irq;
			firq_s1    <= accept & fire_firq;
			use_ram_s1 <= accept & use_ram;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_imm_s1 <= rd_imm;
		end
	end

	assign done        = done_s1;
	assign read_data   = done_s1 ? (use_ram_s1 ? ram_rdata : rd_imm_s1) : '0;
	assign assert_irq  = irq_s1;
	assign assert_firq = firq_s1;

	`ISR_ASSERT(a_one_route, done |-> !(assert_irq && assert_firq), "both routes fired")
	`ISR_ASSERT(a_done_follows_accept, done |-> $past(start && !busy), "done without beat")
	`ISR_ASSERT(a_no_done_while_clearing, busy |-> !done, "result during clear sweep")
	`ISR_ASSERT(a_firq_needs_mode, assert_firq |-> $past(firq_on_q), "fast line while off")
	`ISR_ASSERT_ALWAYS(a_reset_clears, !arst_n |=> !done && busy, "outputs active in reset")

endmodule
